// ===== rtl/core/q_encoding_decoder_defines.svh =====
// Assertion macros used by the Q-form decoder front end.
`ifndef Q_ENCODING_DECODER_DEFINES_SVH
`define Q_ENCODING_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define QED_ASSERT_IMPL(label, clock, resetn, pre, post) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (pre) |-> (post)) \
        else $error("Q decoder check failed");
`define QED_ASSERT_NEXT(label, clock, resetn, pre, post) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (pre) |=> (post)) \
        else $error("Q decoder check failed");
`else
`define QED_ASSERT_IMPL(label, clock, resetn, pre, post)
`define QED_ASSERT_NEXT(label, clock, resetn, pre, post)
`endif

`endif

// ===== rtl/core/qed_pkg.sv =====
// Types, character codes and hex helpers for the Q-form decoder.
`default_nettype none

package qed_pkg;

    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_t;

    // One queued command: up to three bytes to emit, in order from data[0].
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic logic is_hex(input logic [7:0] b);
        logic digit;
        logic upper;
        logic lower;
        digit = (b >= 8'h30) && (b <= 8'h39);
        upper = (b >= 8'h41) && (b <= 8'h46);
        lower = (b >= 8'h61) && (b <= 8'h66);
        return digit || upper || lower;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        if (b[6])
        begin
            v = b[3:0] + 4'd9;
        end
        else
        begin
            v = b[3:0];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qed_front.sv =====
// Front end: accepts raw bytes, tracks pending escapes and builds emit commands.
`default_nettype none
`include "q_encoding_decoder_defines.svh"

module qed_front
    import qed_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire in_t           item,
    input  wire queue_status_t q_status,
    output logic               push,
    output cmd_t               cmd
);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_EQ    = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    pend_t      pend_reg;
    pend_t      pend_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;
    logic       hex;
    logic       fresh_emit;
    logic       fresh_pend;
    logic [7:0] fresh_byte;

    assign item_stall = q_status.full;
    assign accept     = item_valid && !item_stall;
    assign hex        = is_hex(item.in_byte);
    assign fresh_pend = (item.in_byte == CH_EQUALS) && !item.in_last;
    assign fresh_emit = !fresh_pend;
    assign fresh_byte = (item.in_byte == CH_UNDERSCORE) ? CH_SPACE : item.in_byte;

    always_comb
    begin
        cmd       = '0;
        cmd.last  = item.in_last;
        pend_next = PEND_NONE;
        held_next = held_reg;
        unique case (pend_reg)
            PEND_EQ:
            begin
                if (hex)
                begin
                    if (item.in_last)
                    begin
                        cmd.data[0] = CH_EQUALS;
                        cmd.data[1] = item.in_byte;
                        cmd.count   = 2'd2;
                    end
                    else
                    begin
                        held_next = item.in_byte;
                        pend_next = PEND_DIGIT;
                    end
                end
                else
                begin
                    cmd.data[0] = CH_EQUALS;
                    cmd.data[1] = fresh_byte;
                    cmd.count   = fresh_emit ? 2'd2 : 2'd1;
                    pend_next   = fresh_pend ? PEND_EQ : PEND_NONE;
                end
            end
            PEND_DIGIT:
            begin
                if (hex)
                begin
                    cmd.data[0] = {hex_value(held_reg), hex_value(item.in_byte)};
                    cmd.count   = 2'd1;
                end
                else
                begin
                    cmd.data[0] = CH_EQUALS;
                    cmd.data[1] = held_reg;
                    cmd.data[2] = fresh_byte;
                    cmd.count   = fresh_emit ? 2'd3 : 2'd2;
                    pend_next   = fresh_pend ? PEND_EQ : PEND_NONE;
                end
            end
            default:
            begin
                cmd.data[0] = fresh_byte;
                cmd.count   = fresh_emit ? 2'd1 : 2'd0;
                pend_next   = fresh_pend ? PEND_EQ : PEND_NONE;
            end
        endcase
    end

    assign push = accept && (cmd.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

    `QED_ASSERT_IMPL(a_held_is_hex, clk, rst_n, pend_reg == PEND_DIGIT, is_hex(held_reg))
    `QED_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && item.in_last, pend_reg == PEND_NONE)
    `QED_ASSERT_IMPL(a_last_pushes, clk, rst_n, accept && item.in_last, push)

endmodule

`default_nettype wire

// ===== rtl/core/qed_queue.sv =====
// Short command queue between the front and back ends, head visible at the output.
`default_nettype none

module qed_queue
    import qed_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire cmd_t    push_cmd,
    input  wire logic    pop,
    output cmd_t         head,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/qed_back.sv =====
// Back end: steps through each queued command and drives the output register.
`default_nettype none

module qed_back
    import qed_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cmd_t          head,
    input  wire queue_status_t q_status,
    output logic               pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output out_t               result
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    out_t       result_reg;
    out_t       result_next;
    logic       slot_free;
    logic       load;
    logic       at_end;

    assign slot_free = !valid_reg || !result_stall;
    assign load      = slot_free && !q_status.empty;
    assign at_end    = (idx_reg == (head.count - 2'd1));
    assign pop       = load && at_end;

    always_comb
    begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        if (slot_free)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next           = 1'b1;
            result_next.out_byte = head.data[idx_reg];
            result_next.out_last = head.last && at_end;
            idx_next             = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/q_encoding_decoder.sv =====
// Top level of the Q-form header decoder: front end, command queue and back end.
// The first decoded byte of a transaction is written to the command queue and then
// to the output register before it is presented.
// One byte per cycle in while the queue is not full; the back end emits one decoded byte per
// cycle unless stalled, so an input byte that yields two or three bytes keeps it busy until all are sent.
// Reset clears the pending escape, the command queue and the output valid flag.
`default_nettype none

module q_encoding_decoder
    import qed_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_stall,
    input  wire in_t  item,
    output logic      result_valid,
    input  wire logic result_stall,
    output out_t      result
);

    queue_status_t q_status;
    cmd_t          push_cmd;
    cmd_t          head;
    logic          push;
    logic          pop;

    qed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .cmd        (push_cmd)
    );

    qed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    qed_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
